FILE: sv/stack_machine_execute_unit_assert.svh
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// Concurrent check on clk_i, masked while rst_ni is low.
`define SME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define SME_NEVER(label, cond, msg) \
  `SME_ASSERT(label, !(cond), msg)

`endif

FILE: sv/sme_pkg.sv
package sme_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned OP_W           = 4;
  localparam int unsigned STATUS_W       = 4;
  localparam int unsigned CFG_W          = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned PROG_DEPTH_DEF  = 1024;
  localparam int unsigned DIV_STEPS       = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_LT    = 4'd4,
    OP_GT    = 4'd5,
    OP_PUSH  = 4'd6,
    OP_JMP   = 4'd7,
    OP_JZ    = 4'd8,
    OP_PRINT = 4'd9,
    OP_HALT  = 4'd10
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 4'd0,
    ST_HALT    = 4'd1,
    ST_OVER    = 4'd2,
    ST_UNDER   = 4'd3,
    ST_DIVZ    = 4'd4,
    ST_TARGET  = 4'd5,
    ST_PCRANGE = 4'd6,
    ST_OPCODE  = 4'd7,
    ST_STOPPED = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_FETCH,
    CS_EXEC,
    CS_FINISH
  } ctl_state_e;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_DIV,
    AS_SIGN
  } alu_state_e;

  typedef struct packed {
    logic              start;
    op_e               op;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic              commit;
    status_e           status;
    logic              print_valid;
    logic [DATA_W-1:0] print_value;
  } res_t;

endpackage

FILE: sv/stack_machine_execute_unit.sv
// Stack-machine execute unit: each s_axis transfer carries one instruction, fetched by the
// user at the pc reported in the previous result (0 after reset), and produces exactly one
// m_axis result with status, next pc, printed value and stack depth. The operand stack sits
// in a single-port-read RAM, so operands are read one per cycle and the ALU is shared by all
// arithmetic. Push, jump, jz, print, halt, faults and stopped items pass decode and finish;
// add, sub, mul, lt and gt also pass fetch and exec, and divide waits in exec on the 32-step
// restoring divider. A new instruction is taken once the previous result is in the output
// register; m_axis backpressure stalls the commit of the following one. Any status other
// than ok stops the unit until reset. The program length is written through cfg_we_i; the
// user must do so only while idle, which the unit itself does not enforce.
module stack_machine_execute_unit import sme_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned PROG_DEPTH  = PROG_DEPTH_DEF,
  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH),
  localparam int unsigned SP_W   = $clog2(STACK_DEPTH + 1),
  localparam int unsigned PC_W   = $clog2(PROG_DEPTH + 1),
  localparam int unsigned RES_W  = STATUS_W + PC_W + DATA_W + SP_W,
  localparam int unsigned OUT_W  = ((RES_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // immediate
  input  logic [OP_W-1:0]   s_axis_tuser,   // operation
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // status, next_pc, print_value, stack_depth
  output logic [0:0]        m_axis_tuser,   // print_valid
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  res_t              res;
  logic [PC_W-1:0]   next_pc;
  logic [SP_W-1:0]   depth;
  logic              out_free;

  logic              m_valid_q;
  logic [RES_W-1:0]  m_data_q;
  logic              m_pvalid_q;

  assign out_free = !m_valid_q || m_axis_tready;

  sme_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sme_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  sme_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .PROG_DEPTH  (PROG_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_imm_i    (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_free_i  (out_free),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .res_o       (res),
    .next_pc_o   (next_pc),
    .depth_o     (depth)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res.commit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.commit) begin
      m_data_q   <= {depth, res.print_value, next_pc, res.status};
      m_pvalid_q <= res.print_valid;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'(m_data_q);
  assign m_axis_tuser  = m_pvalid_q;

endmodule

FILE: sv/sme_ram.sv
module sme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/sme_alu.sv
module sme_alu import sme_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  alu_state_e        state_q, state_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic              neg_q, neg_d;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] lhs_mag;
  logic [DATA_W-1:0] rhs_mag;
  logic [DATA_W-1:0] mul_lo;
  logic [DATA_W-1:0] simple_res;

  assign rem_sh  = {rem_q, quo_q[DATA_W-1]};
  assign diff    = rem_sh - {1'b0, dvs_q};
  assign lhs_mag = req_i.lhs[DATA_W-1] ? -req_i.lhs : req_i.lhs;
  assign rhs_mag = req_i.rhs[DATA_W-1] ? -req_i.rhs : req_i.rhs;
  assign mul_lo  = req_i.lhs * req_i.rhs;

  always_comb begin
    case (req_i.op)
      OP_ADD:  simple_res = req_i.lhs + req_i.rhs;
      OP_SUB:  simple_res = req_i.lhs - req_i.rhs;
      OP_MUL:  simple_res = mul_lo;
      OP_LT:   simple_res = DATA_W'($signed(req_i.lhs) < $signed(req_i.rhs));
      OP_GT:   simple_res = DATA_W'($signed(req_i.lhs) > $signed(req_i.rhs));
      default: simple_res = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    res_d   = res_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    unique case (state_q)
      AS_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == OP_DIV) begin
            rem_d   = '0;
            quo_d   = lhs_mag;
            dvs_d   = rhs_mag;
            neg_d   = req_i.lhs[DATA_W-1] ^ req_i.rhs[DATA_W-1];
            cnt_d   = '0;
            state_d = AS_DIV;
          end else begin
            res_d  = simple_res;
            done_d = 1'b1;
          end
        end
      end
      AS_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (!diff[DATA_W]) begin
          rem_d = diff[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = AS_SIGN;
        end
      end
      AS_SIGN: begin
        res_d   = neg_q ? -quo_q : quo_q;
        done_d  = 1'b1;
        state_d = AS_IDLE;
      end
      default: state_d = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

FILE: sv/sme_ctrl.sv
`include "stack_machine_execute_unit_assert.svh"

module sme_ctrl import sme_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned PROG_DEPTH  = PROG_DEPTH_DEF,
  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH),
  localparam int unsigned SP_W   = $clog2(STACK_DEPTH + 1),
  localparam int unsigned PC_W   = $clog2(PROG_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   in_op_i,
  input  logic [DATA_W-1:0] in_imm_i,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              out_free_i,
  output logic              ram_we_o,
  output logic [ADDR_W-1:0] ram_waddr_o,
  output logic [DATA_W-1:0] ram_wdata_o,
  output logic [ADDR_W-1:0] ram_raddr_o,
  input  logic [DATA_W-1:0] ram_rdata_i,
  output alu_req_t          alu_req_o,
  input  alu_rsp_t          alu_rsp_i,
  output res_t              res_o,
  output logic [PC_W-1:0]   next_pc_o,
  output logic [SP_W-1:0]   depth_o
);

  localparam int unsigned CMP_W = (PC_W > CFG_W) ? PC_W : CFG_W;

  ctl_state_e        state_q, state_d;
  op_e               op_q, op_d;
  logic [DATA_W-1:0] imm_q, imm_d;
  logic [DATA_W-1:0] top_q, top_d;
  logic [SP_W-1:0]   sp_q, sp_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic              stopped_q, stopped_d;
  logic [CFG_W-1:0]  psize_q, psize_d;
  status_e           status_q, status_d;
  logic [SP_W-1:0]   sp_nxt_q, sp_nxt_d;
  logic [PC_W-1:0]   pc_nxt_q, pc_nxt_d;
  logic              wr_q, wr_d;
  logic [ADDR_W-1:0] waddr_q, waddr_d;
  logic [DATA_W-1:0] wdata_q, wdata_d;
  logic              pvalid_q, pvalid_d;
  logic [DATA_W-1:0] pv_q, pv_d;

  logic [SP_W-1:0]   sp_m1, sp_m2, sp_p1;
  logic [PC_W-1:0]   pc_p1;
  logic [CMP_W-1:0]  psize_ext, eff_size;
  logic              pc_bad, tgt_ok, t_zero, t_lt2, t_full, top_zero;
  logic              commit;

  assign sp_m1     = sp_q - SP_W'(1);
  assign sp_m2     = sp_q - SP_W'(2);
  assign sp_p1     = sp_q + SP_W'(1);
  assign pc_p1     = pc_q + PC_W'(1);
  assign psize_ext = CMP_W'(psize_q);
  assign eff_size  = (psize_ext > CMP_W'(PROG_DEPTH)) ? CMP_W'(PROG_DEPTH) : psize_ext;
  assign pc_bad    = CMP_W'(pc_q) >= eff_size;
  assign tgt_ok    = !imm_q[DATA_W-1] && (imm_q < DATA_W'(eff_size));
  assign t_zero    = sp_q == '0;
  assign t_lt2     = sp_q < SP_W'(2);
  assign t_full    = sp_q >= SP_W'(STACK_DEPTH);
  assign top_zero  = ram_rdata_i == '0;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    imm_d     = imm_q;
    top_d     = top_q;
    sp_d      = sp_q;
    pc_d      = pc_q;
    stopped_d = stopped_q;
    psize_d   = psize_q;
    status_d  = status_q;
    sp_nxt_d  = sp_nxt_q;
    pc_nxt_d  = pc_nxt_q;
    wr_d      = wr_q;
    waddr_d   = waddr_q;
    wdata_d   = wdata_q;
    pvalid_d  = pvalid_q;
    pv_d      = pv_q;
    in_ready_o  = 1'b0;
    commit      = 1'b0;
    ram_we_o    = 1'b0;
    ram_raddr_o = sp_m2[ADDR_W-1:0];
    alu_req_o   = '0;

    if (cfg_we_i) begin
      psize_d = cfg_wdata_i;
    end

    unique case (state_q)
      CS_IDLE: begin
        in_ready_o  = 1'b1;
        ram_raddr_o = sp_m1[ADDR_W-1:0];
        if (in_valid_i) begin
          op_d    = op_e'(in_op_i);
          imm_d   = in_imm_i;
          state_d = CS_DECODE;
        end
      end
      CS_DECODE: begin
        top_d    = ram_rdata_i;
        status_d = ST_OK;
        sp_nxt_d = sp_q;
        pc_nxt_d = pc_p1;
        wr_d     = 1'b0;
        waddr_d  = sp_m2[ADDR_W-1:0];
        wdata_d  = imm_q;
        pvalid_d = 1'b0;
        pv_d     = '0;
        state_d  = CS_FINISH;
        if (stopped_q) begin
          status_d = ST_STOPPED;
        end else if (pc_bad) begin
          status_d = ST_PCRANGE;
        end else begin
          unique case (op_q) inside
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT: begin
              // zero divisor is flagged ahead of a missing left operand
              if (op_q == OP_DIV && t_zero) begin
                status_d = ST_UNDER;
              end else if (op_q == OP_DIV && top_zero) begin
                status_d = ST_DIVZ;
              end else if (t_lt2) begin
                status_d = ST_UNDER;
              end else begin
                sp_nxt_d = sp_m1;
                wr_d     = 1'b1;
                state_d  = CS_FETCH;
              end
            end
            OP_PUSH: begin
              if (t_full) begin
                status_d = ST_OVER;
              end else begin
                wr_d     = 1'b1;
                waddr_d  = sp_q[ADDR_W-1:0];
                sp_nxt_d = sp_p1;
              end
            end
            OP_JMP: begin
              if (!tgt_ok) begin
                status_d = ST_TARGET;
              end else begin
                pc_nxt_d = imm_q[PC_W-1:0];
              end
            end
            OP_JZ: begin
              if (t_zero) begin
                status_d = ST_UNDER;
              end else if (top_zero) begin
                if (!tgt_ok) begin
                  status_d = ST_TARGET;
                end else begin
                  pc_nxt_d = imm_q[PC_W-1:0];
                  sp_nxt_d = sp_m1;
                end
              end else begin
                sp_nxt_d = sp_m1;
              end
            end
            OP_PRINT: begin
              if (t_zero) begin
                status_d = ST_UNDER;
              end else begin
                pvalid_d = 1'b1;
                pv_d     = ram_rdata_i;
                sp_nxt_d = sp_m1;
              end
            end
            OP_HALT: status_d = ST_HALT;
            default: status_d = ST_OPCODE;
          endcase
        end
      end
      CS_FETCH: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = op_q;
        alu_req_o.lhs   = ram_rdata_i;
        alu_req_o.rhs   = top_q;
        state_d         = CS_EXEC;
      end
      CS_EXEC: begin
        if (alu_rsp_i.done) begin
          wdata_d = alu_rsp_i.result;
          state_d = CS_FINISH;
        end
      end
      CS_FINISH: begin
        if (out_free_i) begin
          commit   = 1'b1;
          ram_we_o = wr_q;
          sp_d     = sp_nxt_q;
          if (status_q == ST_OK || status_q == ST_HALT) begin
            pc_d = pc_nxt_q;
          end
          if (status_q != ST_OK) begin
            stopped_d = 1'b1;
          end
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CS_IDLE;
      sp_q      <= '0;
      pc_q      <= '0;
      stopped_q <= 1'b0;
      psize_q   <= CFG_RESET;
    end else begin
      state_q   <= state_d;
      sp_q      <= sp_d;
      pc_q      <= pc_d;
      stopped_q <= stopped_d;
      psize_q   <= psize_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    imm_q    <= imm_d;
    top_q    <= top_d;
    status_q <= status_d;
    sp_nxt_q <= sp_nxt_d;
    pc_nxt_q <= pc_nxt_d;
    wr_q     <= wr_d;
    waddr_q  <= waddr_d;
    wdata_q  <= wdata_d;
    pvalid_q <= pvalid_d;
    pv_q     <= pv_d;
  end

  assign ram_waddr_o       = waddr_q;
  assign ram_wdata_o       = wdata_q;
  assign res_o.commit      = commit;
  assign res_o.status      = status_q;
  assign res_o.print_valid = pvalid_q;
  assign res_o.print_value = pv_q;
  assign next_pc_o         = pc_d;
  assign depth_o           = sp_d;

  `SME_ASSERT(a_sp_in_range, sp_q <= SP_W'(STACK_DEPTH), "stack pointer beyond capacity")
  `SME_ASSERT(a_stop_sticky, stopped_q |=> stopped_q, "stopped flag cleared without reset")
  `SME_ASSERT(a_stopped_frozen, commit && stopped_q |-> pc_d == pc_q && sp_d == sp_q && !ram_we_o, "state changed while stopped")
  `SME_NEVER(a_alu_done_stray, alu_rsp_i.done && state_q != CS_EXEC, "ALU result with no waiting op")

endmodule

FILE: tb/stack_machine_execute_unit_test.sv
`timescale 1ns / 1ps

module stack_machine_execute_unit_test;
  import sme_pkg::*;

  localparam int PC_BITS = 11;
  localparam int SP_BITS = 9;
  localparam int RES_BITS = 56;
  localparam int PC_LO = STATUS_W;
  localparam int PV_LO = PC_LO + PC_BITS;
  localparam int SD_LO = PV_LO + DATA_W;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 60;
  localparam int CYCLE_LIMIT = 600000;

  localparam op_e ARITH_OPS [6] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT};
  localparam logic [DATA_W-1:0] EDGE_WORDS [5] =
    '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

  typedef struct packed {
    status_e           status;
    logic [10:0]       npc;
    logic              pvalid;
    logic [DATA_W-1:0] pval;
    logic [8:0]        depth;
  } outcome_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] imm;
    bit                typed;
    outcome_t          want;
  } step_row_t;

  typedef enum int {
    FK_HALT, FK_OVER, FK_UNDER, FK_DIVZ, FK_TARGET, FK_PCRANGE, FK_OPCODE, FK_NOSIZE
  } fault_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic [DATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0] s_tuser = '0;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic [RES_BITS-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  // predictor state
  logic [DATA_W-1:0] opstack [STACK_DEPTH_DEF];
  logic [8:0] stack_ptr = '0;
  logic [10:0] prog_ctr = '0;
  bit is_stopped = 1'b0;
  logic [CFG_W-1:0] prog_size = CFG_RESET;

  outcome_t pending_results [$];
  step_row_t script [$];
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_armed = 1'b0;
  int fill_bias = 1;
  int n_errors = 0;
  int n_issued = 0;
  int n_checked = 0;
  int n_prints = 0;
  int depth_peak = 0;
  int cycles = 0;

  stack_machine_execute_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("stack_machine_execute_unit_test: errors");
      $finish;
    end
  end

  function automatic logic [10:0] eff_size();
    return (prog_size > PROG_DEPTH_DEF) ? 11'(PROG_DEPTH_DEF) : prog_size;
  endfunction

  function automatic bit target_ok(input logic [DATA_W-1:0] imm);
    return !imm[31] && (imm < {21'd0, eff_size()});
  endfunction

  // signed divide, truncating toward zero; min / -1 wraps
  function automatic logic [DATA_W-1:0] quotient(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] ma, mb, q;
    ma = a[31] ? 32'd0 - a : a;
    mb = b[31] ? 32'd0 - b : b;
    q = ma / mb;
    return (a[31] ^ b[31]) ? 32'd0 - q : q;
  endfunction

  function automatic outcome_t execute_instr(input logic [OP_W-1:0] op,
                                             input logic [DATA_W-1:0] imm);
    outcome_t o;
    logic [10:0] npc;
    logic [DATA_W-1:0] r, l, v;
    o = '0;
    o.status = ST_OK;
    if (is_stopped) begin
      o.status = ST_STOPPED;
    end else if (prog_ctr >= eff_size()) begin
      o.status = ST_PCRANGE;
    end else begin
      npc = prog_ctr + 11'd1;
      r = (stack_ptr > 0) ? opstack[stack_ptr - 1] : '0;
      l = (stack_ptr > 1) ? opstack[stack_ptr - 2] : '0;
      case (op)
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT: begin
          if (op == OP_DIV && stack_ptr == 0) begin
            o.status = ST_UNDER;
          end else if (op == OP_DIV && r == 0) begin
            o.status = ST_DIVZ;
          end else if (stack_ptr < 2) begin
            o.status = ST_UNDER;
          end else begin
            case (op)
              OP_ADD: v = l + r;
              OP_SUB: v = l - r;
              OP_MUL: v = l * r;
              OP_DIV: v = quotient(l, r);
              OP_LT: v = ($signed(l) < $signed(r)) ? 32'd1 : 32'd0;
              default: v = ($signed(l) > $signed(r)) ? 32'd1 : 32'd0;
            endcase
            opstack[stack_ptr - 2] = v;
            stack_ptr = stack_ptr - 1;
          end
        end
        OP_PUSH: begin
          if (stack_ptr >= STACK_DEPTH_DEF) begin
            o.status = ST_OVER;
          end else begin
            opstack[stack_ptr] = imm;
            stack_ptr = stack_ptr + 1;
          end
        end
        OP_JMP: begin
          if (!target_ok(imm)) o.status = ST_TARGET;
          else npc = imm[10:0];
        end
        OP_JZ: begin
          if (stack_ptr == 0) begin
            o.status = ST_UNDER;
          end else if (r == 0) begin
            if (!target_ok(imm)) begin
              o.status = ST_TARGET;
            end else begin
              npc = imm[10:0];
              stack_ptr = stack_ptr - 1;
            end
          end else begin
            stack_ptr = stack_ptr - 1;
          end
        end
        OP_PRINT: begin
          if (stack_ptr == 0) begin
            o.status = ST_UNDER;
          end else begin
            o.pvalid = 1'b1;
            o.pval = r;
            stack_ptr = stack_ptr - 1;
          end
        end
        OP_HALT: o.status = ST_HALT;
        default: o.status = ST_OPCODE;
      endcase
      if (o.status == ST_OK || o.status == ST_HALT) prog_ctr = npc;
    end
    if (o.status != ST_OK) is_stopped = 1'b1;
    o.npc = prog_ctr;
    o.depth = stack_ptr;
    if (int'(stack_ptr) > depth_peak) depth_peak = stack_ptr;
    return o;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    int s;
    case ($urandom_range(0, 5))
      0: return EDGE_WORDS[$urandom_range(0, 4)];
      1, 2: begin
        s = $urandom_range(0, 16);
        return 32'(s - 8);
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_instr(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] imm,
                             input bit typed, input outcome_t want);
    int gap;
    outcome_t pred;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= imm;
    s_tuser <= op;
    @(negedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    @(posedge clk_i);
    pred = execute_instr(op, imm);
    pending_results.push_back(typed ? want : pred);
    n_issued++;
  endtask

  // keeps the pc in range by jumping home first when needed
  task automatic guarded(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] imm);
    if (prog_ctr + 11'd1 >= eff_size()) issue_instr(OP_JMP, '0, 1'b0, '0);
    issue_instr(op, imm, 1'b0, '0);
  endtask

  task automatic pick_instr(output logic [OP_W-1:0] op, output logic [DATA_W-1:0] imm);
    logic [10:0] lim;
    logic [DATA_W-1:0] tos;
    int push_pct, k;
    bit ok;
    lim = eff_size();
    tos = (stack_ptr != 0) ? opstack[stack_ptr - 1] : '0;
    push_pct = (fill_bias == 2) ? 88 : (fill_bias == 1) ? 45 : 12;
    if (prog_ctr + 11'd1 >= lim) begin
      imm = $urandom_range(0, lim - 1);
      op = (stack_ptr != 0 && tos == 0 && $urandom_range(0, 1)) ? OP_JZ : OP_JMP;
      return;
    end
    ok = 1'b0;
    while (!ok) begin
      imm = rand_word();
      if ($urandom_range(0, 99) < push_pct) begin
        op = OP_PUSH;
        ok = stack_ptr < STACK_DEPTH_DEF;
      end else begin
        k = $urandom_range(0, 11);
        if (k < 6) begin
          op = ARITH_OPS[k];
          ok = stack_ptr >= 2 && (op != OP_DIV || tos != 0);
        end else if (k == 6) begin
          op = OP_JMP;
          imm = $urandom_range(0, lim - 1);
          ok = 1'b1;
        end else if (k < 9) begin
          op = OP_JZ;
          if (tos == 0) imm = $urandom_range(0, lim - 1);
          ok = stack_ptr != 0;
        end else if (k < 11) begin
          op = OP_PRINT;
          ok = stack_ptr != 0;
        end else begin
          op = OP_PUSH;
          ok = stack_ptr < STACK_DEPTH_DEF;
        end
      end
    end
  endtask

  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_prog_len(input logic [CFG_W-1:0] value);
    drain_outputs();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    prog_size = value;
  endtask

  task automatic force_fault(input fault_kind_e kind);
    logic [10:0] lim;
    logic [DATA_W-1:0] bad;
    int k;
    lim = eff_size();
    bad = $urandom_range(0, 1) ? {1'b1, 31'($urandom)} : 32'(lim) + $urandom_range(0, 4096);
    case (kind)
      FK_HALT: guarded(OP_HALT, rand_word());
      FK_OVER: begin
        while (stack_ptr < STACK_DEPTH_DEF) guarded(OP_PUSH, rand_word());
        guarded(OP_PUSH, rand_word());
      end
      FK_UNDER: begin
        while (stack_ptr != 0) guarded(OP_PRINT, rand_word());
        k = $urandom_range(0, 7);
        if (k < 6) begin
          if ($urandom_range(0, 1)) guarded(OP_PUSH, $urandom | 32'd1);
          guarded(ARITH_OPS[k], rand_word());
        end else begin
          guarded((k == 6) ? OP_JZ : OP_PRINT, rand_word());
        end
      end
      FK_DIVZ: begin
        guarded(OP_PUSH, '0);
        guarded(OP_DIV, rand_word());
      end
      FK_TARGET: begin
        if ($urandom_range(0, 1)) begin
          guarded(OP_JMP, bad);
        end else begin
          guarded(OP_PUSH, '0);
          guarded(OP_JZ, bad);
        end
      end
      FK_PCRANGE: begin
        issue_instr(OP_JMP, 32'(lim - 11'd1), 1'b0, '0);
        issue_instr((stack_ptr < STACK_DEPTH_DEF) ? OP_PUSH : OP_PRINT, rand_word(), 1'b0, '0);
        issue_instr(4'($urandom_range(0, 15)), rand_word(), 1'b0, '0);
      end
      FK_OPCODE: guarded(4'(OP_HALT) + 4'($urandom_range(1, 5)), rand_word());
      default: begin
        set_prog_len('0);
        issue_instr(4'($urandom_range(0, 15)), rand_word(), 1'b0, '0);
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  task automatic check_result();
    outcome_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result transfer, actual %0h", $time, m_axis_tdata);
      n_errors++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("status", 32'(want.status), 32'(m_axis_tdata[PC_LO-1:0]));
    compare_field("next_pc", 32'(want.npc), 32'(m_axis_tdata[PV_LO-1:PC_LO]));
    compare_field("print_valid", 32'(want.pvalid), 32'(m_axis_tuser[0]));
    compare_field("print_value", want.pval, m_axis_tdata[SD_LO-1:PV_LO]);
    compare_field("stack_depth", 32'(want.depth), 32'(m_axis_tdata[SD_LO+SP_BITS-1:SD_LO]));
    if (want.pvalid) n_prints++;
    n_checked++;
  endtask

  // result side
  initial begin
    int gap;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_armed) begin
        hold_armed = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = rx_idle ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(negedge clk_i);
      while (!m_axis_tvalid) begin
        @(posedge clk_i);
        @(negedge clk_i);
      end
      check_result();
      @(posedge clk_i);
    end
  end

  task automatic add_step(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] imm,
                          input bit typed, input status_e st, input int npc,
                          input logic [DATA_W-1:0] pval, input int depth);
    step_row_t row;
    row.op = op;
    row.imm = imm;
    row.typed = typed;
    row.want = '0;
    row.want.status = st;
    row.want.npc = 11'(npc);
    row.want.pvalid = (op == OP_PRINT);
    row.want.pval = pval;
    row.want.depth = 9'(depth);
    script.push_back(row);
  endtask

  // stimulus
  initial begin
    int plan_size [6];
    int plan_len [6];
    int plan_bias [6];
    logic [OP_W-1:0] op;
    logic [DATA_W-1:0] imm;
    fault_kind_e kind;

    add_step(OP_PUSH, 32'h7FFF_FFFF, 1, ST_OK, 1, '0, 1);
    add_step(OP_PUSH, 32'h0000_0001, 1, ST_OK, 2, '0, 2);
    add_step(OP_ADD, '0, 0, ST_OK, 0, '0, 0);
    add_step(OP_PRINT, '0, 1, ST_OK, 4, 32'h8000_0000, 0);
    add_step(OP_PUSH, 32'h8000_0000, 0, ST_OK, 0, '0, 0);
    add_step(OP_PUSH, 32'hFFFF_FFFF, 0, ST_OK, 0, '0, 0);
    add_step(OP_DIV, '0, 0, ST_OK, 0, '0, 0);
    add_step(OP_PRINT, '0, 1, ST_OK, 8, 32'h8000_0000, 0);
    add_step(OP_PUSH, 32'hFFFF_FFF9, 0, ST_OK, 0, '0, 0);
    add_step(OP_PUSH, 32'h0000_0002, 0, ST_OK, 0, '0, 0);
    add_step(OP_DIV, '0, 0, ST_OK, 0, '0, 0);
    add_step(OP_PUSH, 32'h0000_0005, 0, ST_OK, 0, '0, 0);
    add_step(OP_SUB, '0, 0, ST_OK, 0, '0, 0);
    add_step(OP_PUSH, 32'h0000_0003, 0, ST_OK, 0, '0, 0);
    add_step(OP_MUL, '0, 0, ST_OK, 0, '0, 0);
    add_step(OP_PUSH, 32'h0000_0004, 0, ST_OK, 0, '0, 0);
    add_step(OP_LT, '0, 0, ST_OK, 0, '0, 0);
    add_step(OP_PUSH, 32'h0000_0000, 0, ST_OK, 0, '0, 0);
    add_step(OP_GT, '0, 0, ST_OK, 0, '0, 0);
    add_step(OP_JZ, 32'h8000_0000, 0, ST_OK, 0, '0, 0);
    add_step(OP_PUSH, 32'h0000_0000, 0, ST_OK, 0, '0, 0);
    add_step(OP_JZ, 32'd25, 0, ST_OK, 0, '0, 0);
    add_step(OP_JMP, 32'd1023, 1, ST_OK, 1023, '0, 0);
    add_step(OP_JMP, 32'd0, 1, ST_OK, 0, '0, 0);

    plan_size = '{2047, 1, 1024, 3, 0, 1023};
    plan_size[4] = $urandom_range(2, 1022);
    plan_len = '{400, 60, 300, 120, 200, 170};
    plan_bias = '{2, 1, 0, 1, 1, 1};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) issue_instr(script[i].op, script[i].imm, script[i].typed, script[i].want);

    for (int p = 0; p < 6; p++) begin
      set_prog_len(11'(plan_size[p]));
      fill_bias = plan_bias[p];
      tx_idle = (p != 3) && ($urandom_range(0, 3) != 0);
      rx_idle = (p != 3) && ($urandom_range(0, 3) != 0);
      if (p == 0) hold_armed = 1'b1;
      repeat (plan_len[p]) begin
        pick_instr(op, imm);
        issue_instr(op, imm, 1'b0, '0);
      end
      issue_instr(OP_JMP, '0, 1'b0, '0);
    end

    tx_idle = $urandom_range(0, 1);
    rx_idle = $urandom_range(0, 1);
    kind = fault_kind_e'($urandom_range(0, 7));
    force_fault(kind);
    // the unit stays stopped from here on
    repeat (12) issue_instr(4'($urandom_range(0, 15)), rand_word(), 1'b0, '0);

    drain_outputs();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("ran %0d instructions over 6 program sizes, %0d results checked, %0d prints",
             n_issued, n_checked, n_prints);
    $display("peak stack depth %0d, run stopped by %s", depth_peak, kind.name());
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("stack_machine_execute_unit_test: clean");
    end else begin
      $display("stack_machine_execute_unit_test: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/sme_pkg.sv
sv/sme_ram.sv
sv/sme_alu.sv
sv/sme_ctrl.sv
sv/stack_machine_execute_unit.sv
tb/stack_machine_execute_unit_test.sv
